>>> hdl/flowshop_pkg.sv
`default_nettype none

package flowshop_pkg;

    // field widths of the item ports
    localparam int JOB_W    = 5;
    localparam int MACH_W   = 3;
    localparam int PTIME_W  = 10;
    localparam int FINISH_W = 20;
    localparam int CFG_W    = 4;

    // default sizes handed to the top level
    localparam int DEF_MAX_JOBS     = 32;
    localparam int DEF_MAX_MACHINES = 8;

    localparam logic [CFG_W-1:0]    CFG_RESET  = 4'd5;
    localparam logic [FINISH_W-1:0] FINISH_MAX = '1;

    // item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_SCHED = 1'b1;

    // token handed from cell to cell
    typedef struct packed {
        logic                valid;
        logic                kind;
        logic [JOB_W-1:0]    job;
        logic [MACH_W-1:0]   machine;
        logic [PTIME_W-1:0]  ptime;
        logic                last;
        logic [FINISH_W-1:0] above;
    } t_tok;

endpackage

`default_nettype wire

>>> hdl/flowshop_ram.sv
`default_nettype none

module flowshop_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/flowshop_cell.sv
`default_nettype none

module flowshop_cell #(
    parameter int MAX_JOBS = 32,
    parameter int CELL_IDX = 0
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_active,
    input  wire flowshop_pkg::t_tok i_tok,
    output flowshop_pkg::t_tok      o_tok
);

    import flowshop_pkg::*;

    localparam int AW = $clog2(MAX_JOBS);
    localparam int XW = (AW > JOB_W) ? AW : JOB_W;

    t_tok                r_a;
    t_tok                r_b;
    t_tok                n_b;
    logic [FINISH_W-1:0] r_row;
    logic [FINISH_W-1:0] n_row;

    logic [XW-1:0]       job_x;
    logic [AW-1:0]       addr;
    logic                we;
    logic                in_ok;
    logic                a_ok;
    logic [PTIME_W-1:0]  rdata;
    logic [PTIME_W-1:0]  ptime;
    logic [FINISH_W-1:0] start;
    logic [FINISH_W:0]   sum;
    logic [FINISH_W-1:0] sat;

    assign job_x = XW'(i_tok.job);
    assign addr  = job_x[AW-1:0];
    assign in_ok = int'(i_tok.job) < MAX_JOBS;
    assign we    = i_en && i_tok.valid && (i_tok.kind == KIND_LOAD) && in_ok
                   && (int'(i_tok.machine) == CELL_IDX);

    // this machine's column of the time table
    flowshop_ram #(
        .WIDTH (PTIME_W),
        .DEPTH (MAX_JOBS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (addr),
        .i_wdata (i_tok.ptime),
        .i_re    (i_en),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    assign a_ok  = int'(r_a.job) < MAX_JOBS;
    assign ptime = a_ok ? rdata : '0;
    assign start = (r_a.above > r_row) ? r_a.above : r_row;
    assign sum   = {1'b0, start} + (FINISH_W + 1)'(ptime);
    assign sat   = sum[FINISH_W] ? FINISH_MAX : sum[FINISH_W-1:0];

    always_comb begin
        n_b   = r_a;
        n_row = r_row;
        if (r_a.valid && (r_a.kind == KIND_SCHED)) begin
            if (i_active) begin
                n_b.above = sat;
                n_row     = sat;
            end
            if (r_a.last) begin
                n_row = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
            r_b.valid <= 1'b0;
            r_row     <= '0;
        end else if (i_en) begin
            r_a   <= i_tok;
            r_b   <= n_b;
            r_row <= n_row;
        end
    end

    assign o_tok = r_b;

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && r_a.valid && (r_a.kind == KIND_SCHED) && r_a.last |=> r_row == '0)
        else $error("row not cleared after last job");

    a_idle_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && r_a.valid && !i_active |=> r_b.above == $past(r_a.above))
        else $error("unused machine changed the completion time");

    a_row_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && r_a.valid && (r_a.kind == KIND_SCHED) && !r_a.last && i_active
        |=> r_row >= $past(r_row))
        else $error("completion time went backwards");

endmodule

`default_nettype wire

>>> hdl/flowshop_obuf.sv
`default_nettype none

module flowshop_obuf (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire logic [flowshop_pkg::FINISH_W-1:0] i_finish,
    input  wire logic                          i_done,
    output logic                               o_full,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic      [flowshop_pkg::FINISH_W-1:0] o_finish,
    output logic                               o_done
);

    import flowshop_pkg::*;

    logic [1:0]          r_cnt;
    logic [FINISH_W-1:0] r_fin0;
    logic [FINISH_W-1:0] r_fin1;
    logic                r_done0;
    logic                r_done1;
    logic                pop;

    assign pop     = (r_cnt != 2'd0) && i_ready;
    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_finish = r_fin0;
    assign o_done   = r_done0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            case ({i_push, pop})
                2'b10: begin
                    if (r_cnt == 2'd0) begin
                        r_fin0  <= i_finish;
                        r_done0 <= i_done;
                    end else begin
                        r_fin1  <= i_finish;
                        r_done1 <= i_done;
                    end
                    r_cnt <= r_cnt + 2'd1;
                end
                2'b01: begin
                    r_fin0  <= r_fin1;
                    r_done0 <= r_done1;
                    r_cnt   <= r_cnt - 2'd1;
                end
                2'b11: begin
                    r_fin0  <= i_finish;
                    r_done0 <= i_done;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hdl/flowshop_makespan.sv
`default_nettype none

// flowshop_makespan: makespan of a job permutation in a permutation flow shop
// input channel (i_in_valid / o_in_ready) carries two kinds of beat:
//   load beat: stores i_proc_time for (i_job_id, i_machine), gives no result
//   schedule beat: runs job i_job_id through the machines in use and gives
//   one result beat with its completion time on the last machine in use;
//   with i_last_job set that value is the makespan and the row is cleared
// output channel (o_out_valid / i_out_ready) carries o_finish_time and
// o_done_res, one beat per schedule beat, in order
// i_cfg_we writes i_cfg_wdata as the machine count; write only while idle
// structure: one cell per machine, each with its own column of the time
// table in a small ram and its own completion time; a beat walks the row as
// a wavefront, each cell a ram read stage then a max/add/saturate stage
// throughput: one beat per cycle while the output buffer is not full,
// set by the per-cell max/add stage
// a two-beat output buffer sits after the last cell; when it holds two
// beats the whole row freezes and o_in_ready drops until one is taken
// reset (synchronous, active low) empties the row and the buffer, clears
// all completion times and sets the machine count to 5; table contents are
// undefined until loaded

module flowshop_makespan #(
    parameter int MAX_JOBS     = flowshop_pkg::DEF_MAX_JOBS,
    parameter int MAX_MACHINES = flowshop_pkg::DEF_MAX_MACHINES
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // input beats
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_kind,
    input  wire logic [flowshop_pkg::JOB_W-1:0]      i_job_id,
    input  wire logic [flowshop_pkg::MACH_W-1:0]     i_machine,
    input  wire logic [flowshop_pkg::PTIME_W-1:0]    i_proc_time,
    input  wire logic                                i_last_job,
    // result beats
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic      [flowshop_pkg::FINISH_W-1:0]   o_finish_time,
    output logic                                     o_done_res,
    // machine count register
    input  wire logic                                i_cfg_we,
    input  wire logic [flowshop_pkg::CFG_W-1:0]      i_cfg_wdata
);

    import flowshop_pkg::*;

    logic [CFG_W-1:0] r_cfg;
    logic             en;
    logic             full;
    logic             push;
    t_tok             tok [MAX_MACHINES+1];

    // machine count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    // whole row advances unless the output buffer is full
    assign en         = !full;
    assign o_in_ready = en;

    // beat entering the first cell, nothing finished above machine 0
    always_comb begin
        tok[0].valid   = i_in_valid;
        tok[0].kind    = i_kind;
        tok[0].job     = i_job_id;
        tok[0].machine = i_machine;
        tok[0].ptime   = i_proc_time;
        tok[0].last    = i_last_job;
        tok[0].above   = '0;
    end

    for (genvar m = 0; m < MAX_MACHINES; m++) begin : g_cell
        logic active;

        // machine 0 always works; a count above MAX_MACHINES covers the row
        assign active = (m == 0) || (int'(r_cfg) > m);

        flowshop_cell #(
            .MAX_JOBS (MAX_JOBS),
            .CELL_IDX (m)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_active (active),
            .i_tok    (tok[m]),
            .o_tok    (tok[m+1])
        );
    end

    // unused cells pass the completion time through, so the row end holds
    // the completion on the last machine in use
    assign push = en && tok[MAX_MACHINES].valid && (tok[MAX_MACHINES].kind == KIND_SCHED);

    flowshop_obuf u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_finish (tok[MAX_MACHINES].above),
        .i_done   (tok[MAX_MACHINES].last),
        .o_full   (full),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_finish (o_finish_time),
        .o_done   (o_done_res)
    );

endmodule

`default_nettype wire
